### rtl/core/sbct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_pkg: shared types and constants
// Geometry, request codes and record types of the block cache tag controller.
// ----------------------------------------------------------------------------
package sbct_pkg;

	localparam int NUM_GROUPS = 16;   // power of two: group is the low block bits
	localparam int WAYS       = 4;
	localparam int USAGE_BITS = 16;
	localparam int ENTRIES    = NUM_GROUPS * WAYS;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int TAG_W      = 4;
	localparam int BLK_W      = 32;
	localparam int REQ_W      = 2;
	localparam int OIDX_W     = 6;

	localparam logic [REQ_W-1:0] REQ_ACCESS = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_WIPE   = 2'd2;

	typedef logic [USAGE_BITS-1:0] usage_t;

	localparam usage_t USAGE_MAX = {USAGE_BITS{1'b1}};

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [BLK_W-1:0] blk;
	} meta_t;

	// compare unit outputs
	typedef struct packed {
		logic tag_eq;
		logic blk_eq;
		logic ge_lo;
		logic le_hi;
		logic lt_min;
	} cmp_t;

	typedef struct packed {
		logic              hit;
		logic [OIDX_W-1:0] entry_index;
		logic              writeback;
		logic [TAG_W-1:0]  wb_tag;
		logic [BLK_W-1:0]  wb_block;
		logic              fill_needed;
	} res_t;

endpackage

### rtl/core/sbct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_if: request and response channels
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface sbct_req_if import sbct_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [TAG_W-1:0] tag;
	logic [BLK_W-1:0] block_num;
	logic [BLK_W-1:0] last_block;
	logic             is_write;

	modport source (output valid, req_type, tag, block_num, last_block, is_write,
		input ready);
	modport sink (input valid, req_type, tag, block_num, last_block, is_write,
		output ready);
endinterface

interface sbct_rsp_if import sbct_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hit;
	logic [OIDX_W-1:0] entry_index;
	logic              writeback;
	logic [TAG_W-1:0]  wb_tag;
	logic [BLK_W-1:0]  wb_block;
	logic              fill_needed;
	logic              last;

	modport source (output valid, hit, entry_index, writeback, wb_tag, wb_block,
		fill_needed, last, input ready);
	modport sink (input valid, hit, entry_index, writeback, wb_tag, wb_block,
		fill_needed, last, output ready);
endinterface

### rtl/core/sbct_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_store: entry record memory
// Tag/block and usage arrays, one write and one registered read per cycle.
// Usage of a never-written entry reads as zero.
// ----------------------------------------------------------------------------
module sbct_store import sbct_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic             meta_we,
	input  meta_t            meta_wdata,
	input  logic             usage_we,
	input  usage_t           usage_wdata,
	output meta_t            rd_meta,
	output usage_t           rd_usage
);

	meta_t  meta_mem [ENTRIES];
	usage_t usage_mem [ENTRIES];

	logic [ENTRIES-1:0] init_q;
	logic               rd_init_q;
	meta_t              meta_rd_q;
	usage_t             usage_rd_q;

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[wr_addr] <= meta_wdata;
		end
		if (usage_we) begin
			usage_mem[wr_addr] <= usage_wdata;
		end
		if (rd_en) begin
			meta_rd_q  <= meta_mem[rd_addr];
			usage_rd_q <= usage_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= '0;
			rd_init_q <= 1'b0;
		end else begin
			if (usage_we) begin
				init_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_init_q <= init_q[rd_addr];
			end
		end
	end

	assign rd_meta  = meta_rd_q;
	assign rd_usage = rd_init_q ? usage_rd_q : '0;

endmodule

### rtl/core/sbct_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbct_cmp: shared compare unit
// Tests one entry record against the request: tag and block match, range
// bounds, and usage against the running minimum.
// ----------------------------------------------------------------------------
module sbct_cmp import sbct_pkg::*; (
	input  meta_t            meta,
	input  usage_t           usage,
	input  logic [TAG_W-1:0] tag,
	input  logic [BLK_W-1:0] lo,
	input  logic [BLK_W-1:0] hi,
	input  usage_t           vmin,
	output cmp_t             res
);

	assign res.tag_eq = (meta.tag == tag);
	assign res.blk_eq = (meta.blk == lo);
	assign res.ge_lo  = (meta.blk >= lo);
	assign res.le_hi  = (meta.blk <= hi);
	assign res.lt_min = (usage < vmin);

endmodule

### rtl/core/set_assoc_block_cache_tags_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_block_cache_tags_core: tag and replacement controller
// Set-associative block cache tags with saturating usage counts, victim
// selection by lowest count, write-back reporting, range flush and wipe.
//
//   channel  dir  words per request       contents
//   req      in   1                       req_type, tag, block_num, last_block,
//                                         is_write
//   rsp      out  1 (access, wipe), 1..64 hit, entry_index, writeback, wb_tag,
//                 (flush)                 wb_block, fill_needed, last
//
// Each entry visit is a memory read then an evaluation in the shared compare
// unit, but the miss update pass reads then writes usage. Unused codes go
// straight to the response. A new request is taken only when idle. Reset
// clears valid, dirty and usage-written flags at once; no clearing pass. A
// stalled response holds the walk when another flush word is ready, and holds
// the final word of any request until the output register frees.
// ----------------------------------------------------------------------------
module set_assoc_block_cache_tags_core import sbct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sbct_req_if.sink  req,
	sbct_rsp_if.source rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_A_RD = 3'd1;
	localparam logic [2:0] ST_A_EV = 3'd2;
	localparam logic [2:0] ST_H_RD = 3'd3;
	localparam logic [2:0] ST_H_WR = 3'd4;
	localparam logic [2:0] ST_W_RD = 3'd5;
	localparam logic [2:0] ST_W_EV = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]       state_q;
	logic [REQ_W-1:0] rtype_q;
	logic [TAG_W-1:0] rtag_q;
	logic [BLK_W-1:0] rblk_q;
	logic [BLK_W-1:0] rlast_q;
	logic             rwr_q;
	logic [GRP_W-1:0] grp_q;
	logic [WAY_W-1:0] way_q;
	logic [WAY_W-1:0] vway_q;
	usage_t           vmin_q;
	logic [IDX_W-1:0] ent_q;
	logic             pend_q;
	res_t             res_q;
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] dirty_q;
	logic             ov_q;
	res_t             out_q;
	logic             olast_q;

	logic [IDX_W-1:0] a_idx;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             meta_we;
	meta_t            meta_wdata;
	logic             usage_we;
	usage_t           usage_wdata;
	meta_t            rd_meta;
	usage_t           rd_usage;
	cmp_t             cmp;
	logic             hit_now;
	logic             qual_now;
	logic             out_free;
	logic             is_victim;
	logic             stall;
	logic             wb_now;

	assign a_idx = IDX_W'(int'(grp_q) * WAYS + int'(way_q));

	assign rd_en   = (state_q == ST_A_RD) || (state_q == ST_H_RD) || (state_q == ST_W_RD);
	assign rd_addr = (state_q == ST_W_RD) ? ent_q : a_idx;
	assign wr_addr = a_idx;

	sbct_store u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.meta_we     (meta_we),
		.meta_wdata  (meta_wdata),
		.usage_we    (usage_we),
		.usage_wdata (usage_wdata),
		.rd_meta     (rd_meta),
		.rd_usage    (rd_usage)
	);

	sbct_cmp u_cmp (
		.meta  (rd_meta),
		.usage (rd_usage),
		.tag   (rtag_q),
		.lo    (rblk_q),
		.hi    (rlast_q),
		.vmin  (vmin_q),
		.res   (cmp)
	);

	assign hit_now   = valid_q[a_idx] && cmp.tag_eq && cmp.blk_eq;
	assign qual_now  = valid_q[ent_q] && dirty_q[ent_q] && cmp.tag_eq && cmp.ge_lo
		&& cmp.le_hi;
	assign out_free  = !ov_q || rsp.ready;
	assign is_victim = (way_q == vway_q);
	assign wb_now    = valid_q[a_idx] && dirty_q[a_idx];
	// a second flush word is found while the previous one cannot leave yet
	assign stall     = (rtype_q == REQ_FLUSH) && qual_now && pend_q && !out_free;

	always_comb begin
		usage_we    = 1'b0;
		usage_wdata = rd_usage;
		meta_we     = 1'b0;
		meta_wdata  = '{tag: rtag_q, blk: rblk_q};
		case (state_q)
			ST_A_EV: begin
				if (hit_now) begin
					usage_we    = 1'b1;
					usage_wdata = (rd_usage == USAGE_MAX) ? rd_usage
						: usage_t'(rd_usage + 1'b1);
				end
			end
			ST_H_WR: begin
				usage_we    = 1'b1;
				usage_wdata = is_victim ? usage_t'(1) : (rd_usage >> 1);
				meta_we     = is_victim;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rtype_q <= '0;
			rtag_q  <= '0;
			rblk_q  <= '0;
			rlast_q <= '0;
			rwr_q   <= 1'b0;
			grp_q   <= '0;
			way_q   <= '0;
			vway_q  <= '0;
			vmin_q  <= '0;
			ent_q   <= '0;
			pend_q  <= 1'b0;
			res_q   <= '0;
			valid_q <= '0;
			dirty_q <= '0;
			ov_q    <= 1'b0;
			out_q   <= '0;
			olast_q <= 1'b0;
		end else begin
			if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						rtype_q <= req.req_type;
						rtag_q  <= req.tag;
						rblk_q  <= req.block_num;
						rlast_q <= req.last_block;
						rwr_q   <= req.is_write;
						grp_q   <= GRP_W'(req.block_num % BLK_W'(NUM_GROUPS));
						way_q   <= '0;
						ent_q   <= '0;
						pend_q  <= 1'b0;
						res_q   <= '0;
						case (req.req_type)
							REQ_ACCESS: state_q <= ST_A_RD;
							REQ_FLUSH,
							REQ_WIPE:   state_q <= ST_W_RD;
							default:    state_q <= ST_FIN;
						endcase
					end
				end
				ST_A_RD: state_q <= ST_A_EV;
				ST_A_EV: begin
					if (hit_now) begin
						res_q.hit         <= 1'b1;
						res_q.entry_index <= OIDX_W'(a_idx);
						if (rwr_q) begin
							dirty_q[a_idx] <= 1'b1;
						end
						state_q <= ST_FIN;
					end else begin
						if (way_q == '0 || cmp.lt_min) begin
							vway_q <= way_q;
							vmin_q <= rd_usage;
						end
						if (way_q == WAY_W'(WAYS - 1)) begin
							way_q   <= '0;
							state_q <= ST_H_RD;
						end else begin
							way_q   <= way_q + 1'b1;
							state_q <= ST_A_RD;
						end
					end
				end
				ST_H_RD: state_q <= ST_H_WR;
				ST_H_WR: begin
					if (is_victim) begin
						res_q.entry_index <= OIDX_W'(a_idx);
						res_q.fill_needed <= 1'b1;
						res_q.writeback   <= wb_now;
						res_q.wb_tag      <= wb_now ? rd_meta.tag : '0;
						res_q.wb_block    <= wb_now ? rd_meta.blk : '0;
						valid_q[a_idx]    <= 1'b1;
						dirty_q[a_idx]    <= rwr_q;
					end
					if (way_q == WAY_W'(WAYS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						way_q   <= way_q + 1'b1;
						state_q <= ST_H_RD;
					end
				end
				ST_W_RD: state_q <= ST_W_EV;
				ST_W_EV: begin
					if (!stall) begin
						if (qual_now) begin
							if (rtype_q == REQ_FLUSH) begin
								// the held word is not the final one
								if (pend_q) begin
									out_q   <= res_q;
									olast_q <= 1'b0;
									ov_q    <= 1'b1;
								end
								res_q.hit         <= 1'b0;
								res_q.entry_index <= OIDX_W'(ent_q);
								res_q.writeback   <= 1'b1;
								res_q.wb_tag      <= rd_meta.tag;
								res_q.wb_block    <= rd_meta.blk;
								res_q.fill_needed <= 1'b0;
								pend_q            <= 1'b1;
								dirty_q[ent_q]    <= 1'b0;
							end else begin
								valid_q[ent_q] <= 1'b0;
								dirty_q[ent_q] <= 1'b0;
							end
						end
						if (ent_q == IDX_W'(ENTRIES - 1)) begin
							state_q <= ST_FIN;
						end else begin
							ent_q   <= ent_q + 1'b1;
							state_q <= ST_W_RD;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_q   <= res_q;
						olast_q <= 1'b1;
						ov_q    <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = ov_q;
	assign rsp.hit         = out_q.hit;
	assign rsp.entry_index = out_q.entry_index;
	assign rsp.writeback   = out_q.writeback;
	assign rsp.wb_tag      = out_q.wb_tag;
	assign rsp.wb_block    = out_q.wb_block;
	assign rsp.fill_needed = out_q.fill_needed;
	assign rsp.last        = olast_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != ST_IDLE))
		else $error("request accepted but sequencer stayed idle");

	a_dirty_valid: assert property (@(posedge clk) disable iff (!arst_n)
		((dirty_q & ~valid_q) == '0))
		else $error("dirty entry is not valid");

	a_one_fill: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(valid_q) <= $countones($past(valid_q)) + 1))
		else $error("more than one entry filled in a cycle");

	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !dirty_q[IDX_W'(res_q.entry_index)])
		else $error("held flush word refers to a dirty entry");

endmodule
